// File: hw/rtl/ipc_pkg.sv
// ipc_pkg: types and codes shared by the irrigation pump controller
// holds the item, configuration and state structs and the led and event codes
// depends on nothing
`timescale 1ns / 1ps

package ipc_pkg;

   // configuration register indexes (byte address is 4 times the index)
   localparam int unsigned CsrAddrWidth = 5;
   localparam logic [2:0] REG_HUMIDITY_LOW     = 3'd0;
   localparam logic [2:0] REG_HUMIDITY_HIGH    = 3'd1;
   localparam logic [2:0] REG_TEMPERATURE_LOW  = 3'd2;
   localparam logic [2:0] REG_TEMPERATURE_HIGH = 3'd3;
   localparam logic [2:0] REG_MIN_GAP_MS       = 3'd4;
   localparam logic [2:0] REG_AUTO_MAX_ON_MS   = 3'd5;
   localparam logic [2:0] REG_MANUAL_ON_MS     = 3'd6;

   // led codes
   localparam logic [1:0] LED_STEADY   = 2'd0;
   localparam logic [1:0] LED_IRRIGATE = 2'd1;
   localparam logic [1:0] LED_ALERT    = 2'd2;

   // event codes
   localparam logic [2:0] EVT_NONE           = 3'd0;
   localparam logic [2:0] EVT_AUTO_START     = 3'd1;
   localparam logic [2:0] EVT_START_BLOCKED  = 3'd2;
   localparam logic [2:0] EVT_STOP_NORMAL    = 3'd3;
   localparam logic [2:0] EVT_STOP_ALERT     = 3'd4;
   localparam logic [2:0] EVT_MANUAL_TIMEOUT = 3'd5;

   // one control cycle
   typedef struct packed {
      logic [31:0]        now_ms;
      logic [13:0]        humidity;
      logic signed [14:0] temperature;
      logic               pump_press;
      logic               mode_press;
   } ipc_item_type;

   // thresholds and timings
   typedef struct packed {
      logic [13:0]        humidity_low;
      logic [13:0]        humidity_high;
      logic signed [14:0] temperature_low;
      logic signed [14:0] temperature_high;
      logic [31:0]        min_gap_ms;
      logic [31:0]        auto_max_on_ms;
      logic [31:0]        manual_on_ms;
   } ipc_cfg_type;

   // controller state carried from item to item
   typedef struct packed {
      logic        manual;
      logic        pump;
      logic [1:0]  led;
      logic [2:0]  event_code;
      logic [31:0] stop_time;
      logic [31:0] start_time;
   } ipc_state_type;

endpackage

// File: hw/rtl/ipc_rules.sv
// ipc_rules: next-state logic of the pump controller for one item
// mode toggle, manual pump toggle, then the automatic or manual rules
// depends on ipc_pkg
`timescale 1ns / 1ps

module ipc_rules
   import ipc_pkg::*;
(
   input  ipc_item_type  item,
   input  ipc_cfg_type   cfg,
   input  ipc_state_type state_cur,
   output ipc_state_type state_nxt
);

   logic               manual;
   logic               pump_tgl;
   logic [31:0]        start_tgl;
   logic               dry_or_hot;
   logic               in_range;
   logic               recovered;
   logic [31:0]        gap;
   logic [31:0]        run_len;
   logic [14:0]        hum_dbl;
   logic [14:0]        hum_mid;
   logic signed [15:0] temp_dbl;
   logic signed [15:0] temp_mid;

   // mode toggle and manual pump toggle
   always_comb begin
      manual    = state_cur.manual ^ item.mode_press;
      pump_tgl  = state_cur.pump;
      start_tgl = state_cur.start_time;
      if (manual && item.pump_press) begin
         pump_tgl = ~state_cur.pump;
         if (!state_cur.pump) begin
            start_tgl = item.now_ms;
         end
      end
   end

   // reading tests, midpoints compared on doubled values
   always_comb begin
      dry_or_hot = (item.humidity < cfg.humidity_low) ||
                   (item.temperature > cfg.temperature_high);
      in_range   = (item.humidity >= cfg.humidity_low) &&
                   (item.humidity <= cfg.humidity_high) &&
                   (item.temperature >= cfg.temperature_low) &&
                   (item.temperature <= cfg.temperature_high);
      hum_dbl    = {item.humidity, 1'b0};
      hum_mid    = {1'b0, cfg.humidity_low} + {1'b0, cfg.humidity_high};
      temp_dbl   = {item.temperature, 1'b0};
      temp_mid   = 16'(cfg.temperature_low) + 16'(cfg.temperature_high);
      recovered  = (hum_dbl > hum_mid) && (temp_dbl < temp_mid);
      gap        = item.now_ms - state_cur.stop_time;
      run_len    = item.now_ms - start_tgl;
   end

   // automatic and manual rules
   always_comb begin
      state_nxt            = state_cur;
      state_nxt.manual     = manual;
      state_nxt.pump       = pump_tgl;
      state_nxt.start_time = start_tgl;
      if (!manual) begin
         if (!pump_tgl && dry_or_hot) begin
            if (gap > cfg.min_gap_ms) begin
               state_nxt.pump       = 1'b1;
               state_nxt.led        = LED_IRRIGATE;
               state_nxt.start_time = item.now_ms;
               state_nxt.event_code = EVT_AUTO_START;
            end else begin
               state_nxt.led        = LED_ALERT;
               state_nxt.event_code = EVT_START_BLOCKED;
            end
         end else if (pump_tgl) begin
            if (recovered || (run_len >= cfg.auto_max_on_ms)) begin
               state_nxt.pump      = 1'b0;
               state_nxt.stop_time = item.now_ms;
               if (in_range) begin
                  state_nxt.led        = LED_STEADY;
                  state_nxt.event_code = EVT_STOP_NORMAL;
               end else begin
                  state_nxt.led        = LED_ALERT;
                  state_nxt.event_code = EVT_STOP_ALERT;
               end
            end
         end else begin
            state_nxt.led = LED_STEADY;
         end
      end else begin
         if (pump_tgl && (run_len >= cfg.manual_on_ms)) begin
            state_nxt.pump       = 1'b0;
            state_nxt.event_code = EVT_MANUAL_TIMEOUT;
         end
         state_nxt.led = in_range ? LED_STEADY : LED_ALERT;
      end
   end

endmodule

// File: hw/rtl/irrigation_pump_controller.sv
// irrigation_pump_controller: top level of the irrigation pump controller
// path: an accepted item goes through the input register, the rules logic and the
// result register; it waits in the input register while the result output stalls
// throughput one item per cycle while the result output is not stalled; the state
// update of one item is combinational between the two registers
// reset: synchronous, active high; clears the state, the valid flags and
// loads the threshold and timing registers with their default values
`timescale 1ns / 1ps

module irrigation_pump_controller
   import ipc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // item input
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] mode_press, [1] pump_press, [16:2] temperature, [30:17] humidity,
   // [62:31] now_ms, [63] zero
   input  logic [63:0]             req_tdata,
   // result output
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] manual_mode, [1] pump_on, [3:2] led_code, [6:4] event_code, [7] zero
   output logic [7:0]              rsp_tdata,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   ipc_cfg_type   cfg_ff,   cfg_in;
   ipc_state_type state_ff, state_in;
   ipc_state_type state_nxt;
   ipc_item_type  item_ff,  item_in;
   logic          in_valid_ff,  in_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff,  rsp_data_in;
   logic          advance;
   logic          cfg_write;
   logic [2:0]    cfg_index;

   // configuration registers
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = csr_paddr[CsrAddrWidth-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_HUMIDITY_LOW:     cfg_in.humidity_low     = csr_pwdata[13:0];
            REG_HUMIDITY_HIGH:    cfg_in.humidity_high    = csr_pwdata[13:0];
            REG_TEMPERATURE_LOW:  cfg_in.temperature_low  = csr_pwdata[14:0];
            REG_TEMPERATURE_HIGH: cfg_in.temperature_high = csr_pwdata[14:0];
            REG_MIN_GAP_MS:       cfg_in.min_gap_ms       = csr_pwdata;
            REG_AUTO_MAX_ON_MS:   cfg_in.auto_max_on_ms   = csr_pwdata;
            REG_MANUAL_ON_MS:     cfg_in.manual_on_ms     = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (cfg_index)
         REG_HUMIDITY_LOW:     csr_prdata = {18'd0, cfg_ff.humidity_low};
         REG_HUMIDITY_HIGH:    csr_prdata = {18'd0, cfg_ff.humidity_high};
         REG_TEMPERATURE_LOW:  csr_prdata = 32'(cfg_ff.temperature_low);
         REG_TEMPERATURE_HIGH: csr_prdata = 32'(cfg_ff.temperature_high);
         REG_MIN_GAP_MS:       csr_prdata = cfg_ff.min_gap_ms;
         REG_AUTO_MAX_ON_MS:   csr_prdata = cfg_ff.auto_max_on_ms;
         REG_MANUAL_ON_MS:     csr_prdata = cfg_ff.manual_on_ms;
         default:              csr_prdata = 32'd0;
      endcase
   end

   // input register, refilled while the held item moves on
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         item_in     = ipc_item_type'(req_tdata[62:0]);
      end
   end

   // rules for the held item
   ipc_rules u_rules (
      .item      (item_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt)
   );

   // state and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         state_in     = state_nxt;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, state_nxt.event_code, state_nxt.led,
                         state_nxt.pump, state_nxt.manual};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.humidity_low     <= 14'd3000;
         cfg_ff.humidity_high    <= 14'd7000;
         cfg_ff.temperature_low  <= 15'sd1800;
         cfg_ff.temperature_high <= 15'sd3500;
         cfg_ff.min_gap_ms       <= 32'd60000;
         cfg_ff.auto_max_on_ms   <= 32'd10000;
         cfg_ff.manual_on_ms     <= 32'd5000;
         state_ff.manual         <= 1'b0;
         state_ff.pump           <= 1'b0;
         state_ff.led            <= LED_STEADY;
         state_ff.event_code     <= EVT_NONE;
         state_ff.stop_time      <= 32'd0;
         state_ff.start_time     <= 32'd0;
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a processed item always leaves a result behind
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("processed item produced no result");

   // a held item that cannot move on stays held
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled item dropped");

   // manual mode never shows watering
   assert property (@(posedge clock) disable iff (reset)
      state_ff.manual |-> (state_ff.led != LED_IRRIGATE))
      else $error("watering led in manual mode");

   // an automatic pump start is logged as such
   assert property (@(posedge clock) disable iff (reset)
      (advance && !state_ff.pump && state_nxt.pump && !state_nxt.manual)
         |-> (state_nxt.event_code == EVT_AUTO_START))
      else $error("automatic start without start event");

endmodule

// File: verif/tb_irrigation_pump_controller.sv
// tb_irrigation_pump_controller: self-checking testbench for the irrigation pump controller
// drives control cycles on the item stream, configures the thresholds over the csr port
// and checks every result against a local model of the controller; needs ipc_pkg
`timescale 1ns / 1ps

module tb_irrigation_pump_controller;
   import ipc_pkg::*;

   // one result item as it appears on rsp_tdata[6:0]
   typedef struct packed {
      logic [2:0] event_code;
      logic [1:0] led;
      logic       pump;
      logic       manual;
   } ctl_status_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   // [0] mode_press, [1] pump_press, [16:2] temperature, [30:17] humidity,
   // [62:31] now_ms, [63] zero
   logic [63:0]             req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   // [0] manual_mode, [1] pump_on, [3:2] led_code, [6:4] event_code, [7] zero
   logic [7:0]              rsp_tdata;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [31:0]             csr_pwdata  = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // controller state as predicted
   logic        ctl_manual;
   logic        ctl_pump;
   logic [1:0]  ctl_led;
   logic [2:0]  ctl_event;
   logic [31:0] ctl_stop_ms;
   logic [31:0] ctl_start_ms;

   // thresholds and timings as last written
   int          cfg_hum_low    = 3000;
   int          cfg_hum_high   = 7000;
   int          cfg_temp_low   = 1800;
   int          cfg_temp_high  = 3500;
   logic [31:0] cfg_min_gap    = 32'd60000;
   logic [31:0] cfg_auto_max   = 32'd10000;
   logic [31:0] cfg_manual_on  = 32'd5000;

   ctl_status_type pending_status[$];
   int          error_count    = 0;
   int          result_count   = 0;
   int          req_idle_pct   = 0;
   int          rsp_stall_pct  = 0;
   logic [31:0] sim_now_ms     = '0;

   irrigation_pump_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("irrigation_pump_controller test failed");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch in result %0d, %s: got %0d, expected %0d",
               result_count, what, got, want);
      error_count++;
   endtask

   // one control cycle: mode toggle, manual pump toggle, then the rules of the mode
   function automatic ctl_status_type predict_control(ipc_item_type it);
      int             temp;
      int             humi;
      logic [31:0]    now;
      logic           dry_or_hot;
      logic           in_range;
      logic           recovered;
      ctl_status_type status;
      temp = {{17{it.temperature[14]}}, it.temperature};
      humi = {18'd0, it.humidity};
      now  = it.now_ms;

      if (it.mode_press)
         ctl_manual = ~ctl_manual;
      if (ctl_manual && it.pump_press) begin
         if (ctl_pump) begin
            ctl_pump = 1'b0;
         end else begin
            ctl_pump     = 1'b1;
            ctl_start_ms = now;
         end
      end

      dry_or_hot = humi < cfg_hum_low || temp > cfg_temp_high;
      in_range   = humi >= cfg_hum_low && humi <= cfg_hum_high &&
                   temp >= cfg_temp_low && temp <= cfg_temp_high;

      if (!ctl_manual) begin
         if (!ctl_pump && dry_or_hot) begin
            // start only once the gap since the last stop is strictly exceeded
            if ((now - ctl_stop_ms) > cfg_min_gap) begin
               ctl_pump     = 1'b1;
               ctl_led      = LED_IRRIGATE;
               ctl_start_ms = now;
               ctl_event    = EVT_AUTO_START;
            end else begin
               ctl_led   = LED_ALERT;
               ctl_event = EVT_START_BLOCKED;
            end
         end else if (ctl_pump) begin
            // midpoints compared on doubled samples
            recovered = (2 * humi > cfg_hum_low + cfg_hum_high) &&
                        (2 * temp < cfg_temp_low + cfg_temp_high);
            if (recovered || (now - ctl_start_ms) >= cfg_auto_max) begin
               ctl_pump    = 1'b0;
               ctl_led     = in_range ? LED_STEADY : LED_ALERT;
               ctl_event   = in_range ? EVT_STOP_NORMAL : EVT_STOP_ALERT;
               ctl_stop_ms = now;
            end
         end else begin
            ctl_led = LED_STEADY;
         end
      end else begin
         if (ctl_pump && (now - ctl_start_ms) >= cfg_manual_on) begin
            ctl_pump  = 1'b0;
            ctl_event = EVT_MANUAL_TIMEOUT;
         end
         ctl_led = in_range ? LED_STEADY : LED_ALERT;
      end

      status.manual     = ctl_manual;
      status.pump       = ctl_pump;
      status.led        = ctl_led;
      status.event_code = ctl_event;
      return status;
   endfunction

   function automatic ipc_item_type cycle_item(logic mode_press, logic pump_press,
                                               int temp, int humi, logic [31:0] now);
      ipc_item_type it;
      it.mode_press  = mode_press;
      it.pump_press  = pump_press;
      it.temperature = 15'(temp);
      it.humidity    = 14'(humi);
      it.now_ms      = now;
      return it;
   endfunction

   // send one item, with random idle cycles ahead of it
   task automatic send_item(ipc_item_type it);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_status.push_back(predict_control(it));
   endtask

   // hold the sender until every expected result is in, then let the pipeline settle
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // two-phase register write, model copy follows the masking of the register widths
   task automatic write_csr(logic [2:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_HUMIDITY_LOW:     cfg_hum_low   = int'(value[13:0]);
         REG_HUMIDITY_HIGH:    cfg_hum_high  = int'(value[13:0]);
         REG_TEMPERATURE_LOW:  cfg_temp_low  = int'($signed(value[14:0]));
         REG_TEMPERATURE_HIGH: cfg_temp_high = int'($signed(value[14:0]));
         REG_MIN_GAP_MS:       cfg_min_gap   = value;
         REG_AUTO_MAX_ON_MS:   cfg_auto_max  = value;
         REG_MANUAL_ON_MS:     cfg_manual_on = value;
         default: ;
      endcase
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin : check_results
      ctl_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_status.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata, 0);
            end else begin
               want = pending_status.pop_front();
               if (rsp_tdata[0] !== want.manual)
                  report_mismatch("manual_mode", rsp_tdata[0], want.manual);
               if (rsp_tdata[1] !== want.pump)
                  report_mismatch("pump_on", rsp_tdata[1], want.pump);
               if (rsp_tdata[3:2] !== want.led)
                  report_mismatch("led_code", rsp_tdata[3:2], want.led);
               if (rsp_tdata[6:4] !== want.event_code)
                  report_mismatch("event_code", rsp_tdata[6:4], want.event_code);
            end
            result_count++;
         end
      end
   end

   // automatic mode under the reset thresholds: blocked, start, hold, both stops, idle
   task automatic test_automatic_rules();
      send_item(cycle_item(1'b0, 1'b0, 2500, 2000, 32'd100));
      send_item(cycle_item(1'b0, 1'b0, 2500, 2000, 32'd60000));
      send_item(cycle_item(1'b0, 1'b0, 2500, 2000, 32'd60001));
      send_item(cycle_item(1'b0, 1'b0, 2500, 4000, 32'd60500));
      send_item(cycle_item(1'b0, 1'b0, 2000, 6000, 32'd61000));
      send_item(cycle_item(1'b0, 1'b0, 2500, 5000, 32'd61100));
      send_item(cycle_item(1'b0, 1'b0, 4000, 5000, 32'd121001));
      send_item(cycle_item(1'b0, 1'b0, 4000, 5000, 32'd131001));
      send_item(cycle_item(1'b0, 1'b0, 2000, 5000, 32'd131002));
   endtask

   // manual toggles, timeout at exactly the run length, presses ignored in auto
   task automatic test_manual_mode();
      send_item(cycle_item(1'b1, 1'b0, 2500, 5000, 32'd131100));
      send_item(cycle_item(1'b0, 1'b1, 2500, 5000, 32'd131200));
      send_item(cycle_item(1'b0, 1'b1, 2500, 5000, 32'd131300));
      send_item(cycle_item(1'b0, 1'b1, 2500, 1000, 32'd131400));
      send_item(cycle_item(1'b0, 1'b0, 2500, 1000, 32'd136399));
      send_item(cycle_item(1'b0, 1'b0, 2500, 5000, 32'd136400));
      send_item(cycle_item(1'b1, 1'b1, 2500, 5000, 32'd136500));
      send_item(cycle_item(1'b1, 1'b1, 2500, 5000, 32'd136600));
      // back to auto with the pump still running from manual
      send_item(cycle_item(1'b1, 1'b0, 2500, 5000, 32'd136700));
      send_item(cycle_item(1'b0, 1'b0, 2500, 5000, 32'd146600));
   endtask

   // sample extremes and timestamp wrap-around
   task automatic test_field_extremes();
      send_item(cycle_item(1'b0, 1'b0, -4000, 0, 32'hFFFF_FFFF));
      send_item(cycle_item(1'b0, 1'b0, 2000, 5000, 32'd9998));
      send_item(cycle_item(1'b0, 1'b0, 2000, 5000, 32'd9999));
      send_item(cycle_item(1'b0, 1'b0, 12500, 10000, 32'd10000));
      send_item(cycle_item(1'b0, 1'b0, -16384, 16383, 32'h5555_5555));
      send_item(cycle_item(1'b0, 1'b0, 16383, 0, 32'hAAAA_AAAA));
      sim_now_ms = 32'hAAAA_AAAA;
   endtask

   // one register setting followed by random control cycles
   task automatic test_random_control(int kind, int count);
      int           hum_low;
      int           hum_high;
      int           temp_low;
      int           temp_high;
      logic [31:0]  min_gap;
      logic [31:0]  auto_max;
      logic [31:0]  manual_on;
      int           step_max;
      int           lo;
      int           hi;
      int           pick;
      ipc_item_type it;

      wait_for_results();
      case (kind)
         0: begin
            // reset bounds, short timings
            hum_low = 3000; hum_high = 7000; temp_low = 1800; temp_high = 3500;
            min_gap   = $urandom_range(0, 3000);
            auto_max  = $urandom_range(1, 2000);
            manual_on = $urandom_range(1, 2000);
            step_max  = 400;
         end
         1: begin
            // widest normal range, zero timings
            hum_low = 0; hum_high = 10000; temp_low = -4000; temp_high = 12500;
            min_gap = '0; auto_max = '0; manual_on = '0;
            step_max = 50;
         end
         2: begin
            // crossed bounds, longest timings
            hum_low = 10000; hum_high = 0; temp_low = 12500; temp_high = -4000;
            min_gap = '1; auto_max = '1; manual_on = '1;
            step_max = 1000;
         end
         3: begin
            // bounds at the register limits, timings anywhere
            hum_low = 16383; hum_high = 16383; temp_low = -16384; temp_high = 16383;
            min_gap = $urandom; auto_max = $urandom; manual_on = $urandom;
            step_max = 5000;
         end
         default: begin
            hum_low   = $urandom_range(0, 10000);
            hum_high  = $urandom_range(0, 10000);
            temp_low  = -4000 + int'($urandom_range(0, 16500));
            temp_high = -4000 + int'($urandom_range(0, 16500));
            min_gap   = $urandom_range(0, 5000);
            auto_max  = $urandom_range(0, 5000);
            manual_on = $urandom_range(0, 5000);
            step_max  = 600;
         end
      endcase
      write_csr(REG_HUMIDITY_LOW, 32'(hum_low));
      write_csr(REG_HUMIDITY_HIGH, 32'(hum_high));
      write_csr(REG_TEMPERATURE_LOW, 32'(temp_low));
      write_csr(REG_TEMPERATURE_HIGH, 32'(temp_high));
      write_csr(REG_MIN_GAP_MS, min_gap);
      write_csr(REG_AUTO_MAX_ON_MS, auto_max);
      write_csr(REG_MANUAL_ON_MS, manual_on);

      repeat (count) begin
         // timestamp mostly creeps forward, now and then jumps anywhere
         if ($urandom_range(0, 99) < 3)
            sim_now_ms = $urandom;
         else
            sim_now_ms = sim_now_ms + $urandom_range(0, step_max);

         // temperature: near the bounds, across the range, or any 15-bit value
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            lo = (cfg_temp_low < cfg_temp_high ? cfg_temp_low : cfg_temp_high) - 400;
            hi = (cfg_temp_low < cfg_temp_high ? cfg_temp_high : cfg_temp_low) + 400;
            it.temperature = 15'(lo + int'($urandom_range(0, hi - lo)));
         end else if (pick < 90) begin
            it.temperature = 15'(-4000 + int'($urandom_range(0, 16500)));
         end else begin
            it.temperature = 15'($urandom);
         end

         // humidity likewise
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            lo = (cfg_hum_low < cfg_hum_high ? cfg_hum_low : cfg_hum_high) - 400;
            hi = (cfg_hum_low < cfg_hum_high ? cfg_hum_high : cfg_hum_low) + 400;
            if (lo < 0)
               lo = 0;
            it.humidity = 14'(lo + int'($urandom_range(0, hi - lo)));
         end else if (pick < 90) begin
            it.humidity = 14'($urandom_range(0, 10000));
         end else begin
            it.humidity = 14'($urandom);
         end

         it.mode_press = ($urandom_range(0, 99) < 6);
         it.pump_press = ($urandom_range(0, 99) < 20);
         it.now_ms     = sim_now_ms;
         send_item(it);

         // occasional full drain in mid stream
         if ($urandom_range(0, 99) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      ctl_manual   = 1'b0;
      ctl_pump     = 1'b0;
      ctl_led      = LED_STEADY;
      ctl_event    = EVT_NONE;
      ctl_stop_ms  = '0;
      ctl_start_ms = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct  = 22;
      rsp_stall_pct = 48;
      test_automatic_rules();
      test_manual_mode();
      test_field_extremes();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 22;
               rsp_stall_pct = 48;
            end
            1: begin
               req_idle_pct  = 48;
               rsp_stall_pct = 22;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int kind = 0; kind < 5; kind++)
            test_random_control(kind, 110);
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("irrigation_pump_controller test passed");
      else
         $display("irrigation_pump_controller test failed");
      $finish;
   end

endmodule
